[rtl/core/cpr_pkg.sv]
package cpr_pkg;

    localparam int BLOCK_BYTES = 32;
    localparam int PORT_COUNT  = 4;
    localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
    localparam int MASK_W      = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [7:0]  CRC_POLY          = 8'h85;
    localparam logic [7:0]  ADDR_LOW_MASK     = 8'hE0;
    localparam logic [15:0] FILL_LOW          = 16'h8000;
    localparam logic [15:0] FILL_HIGH         = 16'h9000;
    localparam logic [7:0]  FILL_IN           = 8'h80;
    localparam logic [7:0]  FILL_OUT          = 8'h00;
    localparam logic [15:0] RUMBLE_ADDR_RESET = 16'hC000;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } op_t;

    typedef enum logic {
        CFG_RAW_PORT_MASK  = 1'b0,
        CFG_RUMBLE_ADDRESS = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        RUMBLE_NONE  = 2'd0,
        RUMBLE_START = 2'd1,
        RUMBLE_STOP  = 2'd2
    } rumble_t;

    // work handed from the decode stage to the beat generator
    typedef struct packed {
        logic       is_read;
        logic       fill_in;
        logic [7:0] crc;      // write: folded CRC before augmentation
        rumble_t    rumble;
    } job_t;

    // augmented CRC-8, data shifted in MSB first
    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] r;
        logic       top;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            top = r[7];
            r   = {r[6:0], data[i]};
            if (top) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic logic [7:0] read_crc(input logic [7:0] fill);
        logic [7:0] r;
        r = 8'h00;
        for (int n = 0; n < BLOCK_BYTES; n++) begin
            r = crc_fold(r, fill);
        end
        return crc_fold(r, 8'h00);
    endfunction

    localparam logic [7:0] READ_CRC_IN  = read_crc(FILL_IN);
    localparam logic [7:0] READ_CRC_OUT = read_crc(FILL_OUT);

endpackage

[rtl/core/cpr_beat_gen.sv]
module cpr_beat_gen (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_ready,
    input  cpr_pkg::job_t     job,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // [7:0] out_byte, [9:8] rumble_event, rest zero
    output logic              m_tuser,   // is_crc
    output logic              m_tlast    // run_end
);

    logic                      gen_valid_reg;
    cpr_pkg::job_t             job_reg;
    logic [cpr_pkg::CNT_W-1:0] cnt_reg;

    logic       m_valid_reg;
    logic [7:0] m_byte_reg;
    logic [1:0] m_rumble_reg;
    logic       m_crc_reg;
    logic       m_last_reg;

    logic       beat_last;
    logic [7:0] beat_byte;
    logic [1:0] beat_rumble;
    logic       out_load;
    logic       gen_done;

    always_comb begin
        beat_last   = !job_reg.is_read || (cnt_reg == cpr_pkg::CNT_W'(cpr_pkg::BLOCK_BYTES));
        beat_rumble = cpr_pkg::RUMBLE_NONE;
        if (!job_reg.is_read) begin
            beat_byte   = cpr_pkg::crc_fold(job_reg.crc, 8'h00);
            beat_rumble = job_reg.rumble;
        end else if (beat_last) begin
            beat_byte = job_reg.fill_in ? cpr_pkg::READ_CRC_IN : cpr_pkg::READ_CRC_OUT;
        end else begin
            beat_byte = job_reg.fill_in ? cpr_pkg::FILL_IN : cpr_pkg::FILL_OUT;
        end
    end

    assign out_load  = gen_valid_reg && (!m_valid_reg || m_tready);
    assign gen_done  = out_load && beat_last;
    assign job_ready = !gen_valid_reg || gen_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end else if (job_valid && job_ready) begin
            gen_valid_reg <= 1'b1;
            cnt_reg       <= '0;
        end else if (gen_done) begin
            gen_valid_reg <= 1'b0;
        end else if (out_load) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (job_valid && job_ready) begin
            job_reg <= job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_byte_reg   <= beat_byte;
            m_rumble_reg <= beat_rumble;
            m_crc_reg    <= beat_last;
            m_last_reg   <= beat_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_rumble_reg, m_byte_reg};
    assign m_tuser  = m_crc_reg;
    assign m_tlast  = m_last_reg;

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_valid_reg |-> cnt_reg <= cpr_pkg::CNT_W'(cpr_pkg::BLOCK_BYTES))
        else $error("beat counter past block length");

    a_job_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid && job_ready |=> gen_valid_reg && cnt_reg == '0)
        else $error("accepted job not loaded");

    a_write_single: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_valid_reg && !job_reg.is_read && out_load |=> !gen_valid_reg || cnt_reg == '0)
        else $error("write job produced more than one beat");

    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        gen_done |=> m_tvalid && m_tlast && m_tuser)
        else $error("final beat of a job lacks last/crc marks");

endmodule

[rtl/core/controller_pak_responder_unit.sv]
// channel   dir  tdata (low bit up)                          tuser   tlast
// s_*       in   port[1:0] addr_high[9:2] addr_low[17:10]     op      final_byte
//                write_byte[25:18], zero pad to 32
// m_*       out  out_byte[7:0] rumble_event[9:8], pad to 16   is_crc  run_end
//
// Write beats are taken one per cycle unless output work stalls; only a final write byte
// to a raw port yields an output beat. A raw-port read yields BLOCK_BYTES + 1 (33) beats,
// one per cycle while m_tready is high, so the output side sets the pace.
// m_tvalid rises once the input beat has passed the input reg, generator and output reg.
// aresetn (sync, active low) clears handshakes, write CRC state, raw mask 0, rumble 0xC000.
// m_tready low holds the output reg; s_tready drops only when output work finds the generator busy.
module controller_pak_responder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [cpr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // port, addr_high, addr_low, write_byte, zero pad
    input  logic        s_tuser,   // op
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte, rumble_event, zero pad
    output logic        m_tuser,   // is_crc
    output logic        m_tlast    // run_end
);

    logic [cpr_pkg::MASK_W-1:0] raw_mask_reg;
    logic [15:0]                rumble_addr_reg;

    logic        in_valid_reg;
    logic        in_op_reg;
    logic [1:0]  in_port_reg;
    logic [7:0]  in_addr_high_reg;
    logic [7:0]  in_addr_low_reg;
    logic [7:0]  in_wbyte_reg;
    logic        in_final_reg;

    logic [7:0]                running_crc_reg, running_crc_next;
    logic [cpr_pkg::CNT_W-1:0] byte_count_reg, byte_count_next;
    logic                      first_nz_reg, first_nz_next;

    logic [15:0]   addr;
    logic          port_raw;
    logic          is_write;
    logic          emits;
    logic          advance;
    logic          do_fold;
    logic          job_valid;
    logic          job_ready;
    cpr_pkg::job_t job;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_mask_reg    <= '0;
            rumble_addr_reg <= cpr_pkg::RUMBLE_ADDR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cpr_pkg::cfg_index_t'(cfg_wr_index))
                cpr_pkg::CFG_RAW_PORT_MASK:  raw_mask_reg    <= cfg_wr_data[cpr_pkg::MASK_W-1:0];
                cpr_pkg::CFG_RUMBLE_ADDRESS: rumble_addr_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // input register
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg        <= s_tuser;
            in_port_reg      <= s_tdata[1:0];
            in_addr_high_reg <= s_tdata[9:2];
            in_addr_low_reg  <= s_tdata[17:10];
            in_wbyte_reg     <= s_tdata[25:18];
            in_final_reg     <= s_tlast;
        end
    end

    // decode and write-block CRC state
    always_comb begin
        addr     = {in_addr_high_reg, in_addr_low_reg & cpr_pkg::ADDR_LOW_MASK};
        port_raw = (32'(in_port_reg) < cpr_pkg::PORT_COUNT) && raw_mask_reg[in_port_reg];
        is_write = cpr_pkg::op_t'(in_op_reg) == cpr_pkg::OP_WRITE;
        emits    = port_raw && (!is_write || in_final_reg);
        do_fold  = byte_count_reg < cpr_pkg::CNT_W'(cpr_pkg::BLOCK_BYTES);

        running_crc_next = running_crc_reg;
        byte_count_next  = byte_count_reg;
        first_nz_next    = first_nz_reg;
        if (do_fold) begin
            running_crc_next = cpr_pkg::crc_fold(running_crc_reg, in_wbyte_reg);
            byte_count_next  = byte_count_reg + 1'b1;
            if (byte_count_reg == '0) begin
                first_nz_next = in_wbyte_reg != 8'h00;
            end
        end

        job.is_read = !is_write;
        job.fill_in = (addr >= cpr_pkg::FILL_LOW) && (addr < cpr_pkg::FILL_HIGH);
        job.crc     = running_crc_next;
        if (addr == rumble_addr_reg) begin
            job.rumble = first_nz_next ? cpr_pkg::RUMBLE_START : cpr_pkg::RUMBLE_STOP;
        end else begin
            job.rumble = cpr_pkg::RUMBLE_NONE;
        end
    end

    assign job_valid = in_valid_reg && emits;
    assign advance   = in_valid_reg && (!emits || job_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_crc_reg <= '0;
            byte_count_reg  <= '0;
            first_nz_reg    <= 1'b0;
        end else if (advance && port_raw && is_write) begin
            if (in_final_reg) begin
                running_crc_reg <= '0;
                byte_count_reg  <= '0;
                first_nz_reg    <= 1'b0;
            end else begin
                running_crc_reg <= running_crc_next;
                byte_count_reg  <= byte_count_next;
                first_nz_reg    <= first_nz_next;
            end
        end
    end

    cpr_beat_gen u_beat_gen (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_count_reg <= cpr_pkg::CNT_W'(cpr_pkg::BLOCK_BYTES))
        else $error("write byte count past block length");

    a_final_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && port_raw && is_write && in_final_reg
        |=> byte_count_reg == '0 && running_crc_reg == '0)
        else $error("write state not cleared after final byte");

    a_read_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !is_write |=> $stable(running_crc_reg) && $stable(byte_count_reg))
        else $error("read disturbed write CRC state");

endmodule
